// ===== rtl/frbm_pkg.sv =====
// Shared types and constants for the frame region blit/mirror engine.
// No dependencies.
`timescale 1ns / 1ps
package frbm_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = COL_W + ROW_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W   = 24;
	localparam int DIM_W   = 9;
	localparam int CRD_W   = 16;

	localparam logic [2:0] REQ_WRITE   = 3'd0;
	localparam logic [2:0] REQ_READ    = 3'd1;
	localparam logic [2:0] REQ_COPY    = 3'd2;
	localparam logic [2:0] REQ_FLIPROW = 3'd3;
	localparam logic [2:0] REQ_FLIPCOL = 3'd4;
	localparam logic [2:0] REQ_REPLACE = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_COORD    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// memory request from the sequencer to one store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  wdata;
	} mem_req_t;
endpackage

// ===== rtl/frame_region_blit_mirror_top.sv =====
// Top level of the frame region blit/mirror engine.
// Depends on frbm_pkg, frbm_ram, frbm_seq.
`timescale 1ns / 1ps
// One request at a time: start is taken when busy is low, and exactly one
// result appears with done high for a single cycle; the receiver cannot stall.
// A region request makes a read pass and a write pass over the single-port
// frame store; a paste writes back only the pixels that land inside the image.
// Color replace scans every pixel of the image.
// Configuration writes are always accepted (cfg_ready is tied high).
module frame_region_blit_mirror_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [15:0] first_col,
	input  logic [15:0] first_row,
	input  logic [15:0] second_col,
	input  logic [15:0] second_row,
	input  logic [15:0] dest_col,
	input  logic [15:0] dest_row,
	input  logic [23:0] pixel_value,
	input  logic [23:0] replacement_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [23:0] read_pixel,
	output logic [1:0]  status
);
	logic [8:0] width_q, height_q, used_w, used_h;
	frbm_pkg::mem_req_t frame_req, region_req;
	logic [23:0] frame_rdata, region_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				frbm_pkg::REG_WIDTH:  width_q  <= cfg_data;
				frbm_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to 1..max
	assign used_w = (width_q == '0) ? 9'd1 :
		(width_q > 9'(frbm_pkg::MAX_WIDTH)) ? 9'(frbm_pkg::MAX_WIDTH) : width_q;
	assign used_h = (height_q == '0) ? 9'd1 :
		(height_q > 9'(frbm_pkg::MAX_HEIGHT)) ? 9'(frbm_pkg::MAX_HEIGHT) : height_q;

	frbm_seq u_seq (
		.clk, .arst_n, .start, .busy, .req_type, .first_col, .first_row,
		.second_col, .second_row, .dest_col, .dest_row, .pixel_value,
		.replacement_value, .used_w, .used_h, .frame_req, .frame_rdata,
		.region_req, .region_rdata, .done, .read_pixel, .status
	);

	frbm_ram #(.WIDTH(frbm_pkg::PIX_W), .DEPTH(frbm_pkg::DEPTH)) u_frame (
		.clk, .we(frame_req.we), .addr(frame_req.addr),
		.wdata(frame_req.wdata), .rdata(frame_rdata)
	);

	frbm_ram #(.WIDTH(frbm_pkg::PIX_W), .DEPTH(frbm_pkg::DEPTH)) u_region (
		.clk, .we(region_req.we), .addr(region_req.addr),
		.wdata(region_req.wdata), .rdata(region_rdata)
	);
endmodule

// ===== rtl/frbm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module frbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/frbm_seq.sv =====
// Request sequencer: checks and clips regions, walks pixels over the stores.
// Depends on frbm_pkg.
`timescale 1ns / 1ps
module frbm_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    req_type,
	input  logic [frbm_pkg::CRD_W-1:0]    first_col,
	input  logic [frbm_pkg::CRD_W-1:0]    first_row,
	input  logic [frbm_pkg::CRD_W-1:0]    second_col,
	input  logic [frbm_pkg::CRD_W-1:0]    second_row,
	input  logic [frbm_pkg::CRD_W-1:0]    dest_col,
	input  logic [frbm_pkg::CRD_W-1:0]    dest_row,
	input  logic [frbm_pkg::PIX_W-1:0]    pixel_value,
	input  logic [frbm_pkg::PIX_W-1:0]    replacement_value,
	input  logic [frbm_pkg::DIM_W-1:0]    used_w,
	input  logic [frbm_pkg::DIM_W-1:0]    used_h,
	output frbm_pkg::mem_req_t            frame_req,
	input  logic [frbm_pkg::PIX_W-1:0]    frame_rdata,
	output frbm_pkg::mem_req_t            region_req,
	input  logic [frbm_pkg::PIX_W-1:0]    region_rdata,
	output logic                          done,
	output logic [frbm_pkg::PIX_W-1:0]    read_pixel,
	output logic [1:0]                    status
);
	localparam int CW = frbm_pkg::COL_W;
	localparam int RW = frbm_pkg::ROW_W;
	localparam int DW = frbm_pkg::DIM_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_RD, S_RDWAIT, S_CAP, S_LOAD, S_LOADW,
		S_STORE, S_STOREW, S_REPL, S_REPLW, S_FIN
	} state_t;

	state_t            state_q;
	logic [2:0]        req_q;
	logic [15:0]       lx_q, ty_q, rx_q, by_q, dx_q, dy_q;
	logic [frbm_pkg::PIX_W-1:0] pv_q, nv_q;
	logic [DW-1:0]     cols_q, rows_q, start_q;
	logic [DW-1:0]     i_q, j_q;
	logic              found_q;
	logic [1:0]        st_q;

	// clipped bounds
	logic [15:0] wm1, hm1, rx_c, ty_c, dy_c;
	assign wm1  = 16'(used_w) - 16'd1;
	assign hm1  = 16'(used_h) - 16'd1;
	assign rx_c = (rx_q >= 16'(used_w)) ? wm1 : rx_q;
	assign ty_c = (ty_q >= 16'(used_h)) ? hm1 : ty_q;
	assign dy_c = (dy_q >= 16'(used_h)) ? hm1 : dy_q;

	// address helpers
	function automatic logic [frbm_pkg::ADDR_W-1:0] fa(input logic [16:0] r,
		input logic [16:0] c);
		fa = {r[RW-1:0], c[CW-1:0]};
	endfunction

	logic [16:0] src_r, src_c, dst_r, dst_c;
	logic [DW-1:0] su, sv;
	assign src_r = 17'(by_q) + 17'(j_q);
	assign src_c = 17'(lx_q) + 17'(i_q);
	assign dst_r = 17'(start_q) + 17'(j_q);
	assign dst_c = 17'(dx_q) + 17'(i_q);
	assign sv = (req_q == frbm_pkg::REQ_FLIPROW) ? rows_q - DW'(1) - j_q : j_q;
	assign su = (req_q == frbm_pkg::REQ_FLIPCOL) ? cols_q - DW'(1) - i_q : i_q;

	// load- and store-phase bounds
	logic last_i_ld, last_j_ld, last_i_st, last_j_st;
	assign last_i_ld = (i_q == cols_q - DW'(1));
	assign last_j_ld = (j_q == rows_q - DW'(1));
	assign last_i_st = (req_q == frbm_pkg::REQ_COPY) ?
		(last_i_ld || (dst_c + 17'd1 >= 17'(used_w))) : last_i_ld;
	assign last_j_st = (req_q == frbm_pkg::REQ_COPY) ?
		(dst_r == 17'(dy_c)) : last_j_ld;

	// replace-scan bounds
	logic last_i_rp, last_j_rp;
	assign last_i_rp = (17'(i_q) == 17'(used_w) - 17'd1);
	assign last_j_rp = (17'(j_q) == 17'(used_h) - 17'd1);

	// memory requests
	always_comb begin
		frame_req  = '0;
		region_req = '0;
		case (state_q)
			S_RD, S_RDWAIT: begin
				// address held through the wait so the read data stays put
				frame_req.addr  = fa(17'(ty_q), 17'(lx_q));
				frame_req.we    = (state_q == S_RD) && (req_q == frbm_pkg::REQ_WRITE);
				frame_req.wdata = pv_q;
			end
			S_LOAD: frame_req.addr = fa(src_r, src_c);
			S_LOADW: begin
				region_req.we    = 1'b1;
				region_req.addr  = fa(17'(j_q), 17'(i_q));
				region_req.wdata = frame_rdata;
			end
			S_STORE: region_req.addr = fa(17'(sv), 17'(su));
			S_STOREW: begin
				frame_req.we    = 1'b1;
				frame_req.wdata = region_rdata;
				frame_req.addr  = (req_q == frbm_pkg::REQ_COPY) ?
					fa(dst_r, dst_c) : fa(src_r, src_c);
			end
			S_REPL: frame_req.addr = fa(17'(j_q), 17'(i_q));
			S_REPLW: begin
				frame_req.we    = (frame_rdata == pv_q);
				frame_req.addr  = fa(17'(j_q), 17'(i_q));
				frame_req.wdata = nv_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done       <= 1'b0;
			read_pixel <= '0;
			status     <= frbm_pkg::ST_OK;
			req_q <= '0; i_q <= '0; j_q <= '0; found_q <= 1'b0; st_q <= '0;
			lx_q <= '0; ty_q <= '0; rx_q <= '0; by_q <= '0; dx_q <= '0; dy_q <= '0;
			pv_q <= '0; nv_q <= '0;
			cols_q <= '0; rows_q <= '0; start_q <= '0;
		end else begin
			done <= (state_q == S_CAP) || (state_q == S_FIN);
			case (state_q)
				S_IDLE: if (start) begin
					req_q <= req_type;
					lx_q <= first_col; ty_q <= first_row;
					rx_q <= second_col; by_q <= second_row;
					dx_q <= dest_col; dy_q <= dest_row;
					pv_q <= pixel_value; nv_q <= replacement_value;
					i_q <= '0; j_q <= '0; found_q <= 1'b0;
					st_q <= frbm_pkg::ST_OK;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					case (req_q)
						frbm_pkg::REQ_WRITE, frbm_pkg::REQ_READ: begin
							if (lx_q >= 16'(used_w) || ty_q >= 16'(used_h)) begin
								st_q <= frbm_pkg::ST_COORD;
								state_q <= S_FIN;
							end else begin
								state_q <= S_RD;
							end
						end
						frbm_pkg::REQ_COPY, frbm_pkg::REQ_FLIPROW,
						frbm_pkg::REQ_FLIPCOL: begin
							cols_q <= DW'(rx_c - lx_q + 16'd1);
							rows_q <= DW'(ty_c - by_q + 16'd1);
							start_q <= ((dy_c + 16'd1) >= (ty_c - by_q + 16'd1)) ?
								DW'(dy_c + 16'd1 - (ty_c - by_q + 16'd1)) : '0;
							if (lx_q >= 16'(used_w) || by_q >= 16'(used_h) ||
								lx_q > rx_c || by_q > ty_c ||
								(req_q == frbm_pkg::REQ_COPY && dx_q >= 16'(used_w)))
							begin
								st_q <= frbm_pkg::ST_COORD;
								state_q <= S_FIN;
							end else begin
								state_q <= S_LOAD;
							end
						end
						frbm_pkg::REQ_REPLACE: state_q <= S_REPL;
						default: state_q <= S_FIN;
					endcase
				end
				S_RD: state_q <= (req_q == frbm_pkg::REQ_READ) ? S_RDWAIT : S_FIN;
				S_RDWAIT: state_q <= S_CAP;
				S_CAP: begin
					read_pixel <= frame_rdata;
					status <= st_q;
					state_q <= S_IDLE;
				end
				S_LOAD: state_q <= S_LOADW;
				S_LOADW: begin
					state_q <= (last_i_ld && last_j_ld) ? S_STORE : S_LOAD;
					if (last_i_ld) begin
						i_q <= '0;
						if (last_j_ld) begin
							j_q <= '0;
						end else begin
							j_q <= j_q + DW'(1);
						end
					end else begin
						i_q <= i_q + DW'(1);
					end
				end
				S_STORE: state_q <= S_STOREW;
				S_STOREW: begin
					state_q <= (last_i_st && last_j_st) ? S_FIN : S_STORE;
					if (last_i_st) begin
						i_q <= '0;
						if (!last_j_st) begin
							j_q <= j_q + DW'(1);
						end
					end else begin
						i_q <= i_q + DW'(1);
					end
				end
				S_REPL: state_q <= S_REPLW;
				S_REPLW: begin
					if (frame_rdata == pv_q) found_q <= 1'b1;
					state_q <= (last_i_rp && last_j_rp) ? S_FIN : S_REPL;
					if (last_i_rp) begin
						i_q <= '0;
						if (last_j_rp) begin
							if (!(found_q || frame_rdata == pv_q)) begin
								st_q <= frbm_pkg::ST_NOTFOUND;
							end
						end else begin
							j_q <= j_q + DW'(1);
						end
					end else begin
						i_q <= i_q + DW'(1);
					end
				end
				S_FIN: begin
					read_pixel <= '0;
					status <= st_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for frame_region_blit_mirror_top: pixel, region and color requests.
// Depends on frbm_pkg and the RTL. It predicts each result and compares status and read data.
`timescale 1ns / 1ps
module testbench;
	typedef struct {
		logic [2:0]  kind;
		logic [15:0] lx, ty, rx, by, dx, dy;
		logic [23:0] pv, nv;
	} blit_req_t;

	typedef struct {
		logic [23:0] pix;
		logic [1:0]  st;
	} blit_res_t;

	typedef struct {
		blit_req_t r;
		bit        known;
		logic [23:0] epix;
		logic [1:0]  est;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [15:0] first_col = '0, first_row = '0, second_col = '0, second_row = '0;
	logic [15:0] dest_col = '0, dest_row = '0;
	logic [23:0] pixel_value = '0, replacement_value = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = frbm_pkg::REG_WIDTH;
	logic [8:0]  cfg_data = '0;
	logic        done;
	logic [23:0] read_pixel;
	logic [1:0]  status;

	frame_region_blit_mirror_top uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [23:0] frame_img [0:frbm_pkg::DEPTH-1];
	logic [23:0] region_buf [0:frbm_pkg::DEPTH-1];
	logic [8:0]  width_reg = 9'd256, height_reg = 9'd256;

	blit_res_t   pending_q[$];
	int          fail_cnt = 0, req_cnt = 0, res_cnt = 0, cfg_cnt = 0;
	int          quiet_cycles = 0;
	bit          allow_idle = 1'b1;
	bit          accepted_now;

	function automatic int used_width();
		return (width_reg == 0) ? 1 : (width_reg > frbm_pkg::MAX_WIDTH) ?
			frbm_pkg::MAX_WIDTH : int'(width_reg);
	endfunction

	function automatic int used_height();
		return (height_reg == 0) ? 1 : (height_reg > frbm_pkg::MAX_HEIGHT) ?
			frbm_pkg::MAX_HEIGHT : int'(height_reg);
	endfunction

	// apply one request to the frame image and return its result
	function automatic blit_res_t blit_predict(blit_req_t r);
		blit_res_t res;
		int w, h, lx, ty, rx, by, dx, dy, cols, rows, first, sv, su, mw;
		bit found;
		mw = frbm_pkg::MAX_WIDTH;
		w = used_width();
		h = used_height();
		lx = r.lx; ty = r.ty; rx = r.rx; by = r.by; dx = r.dx; dy = r.dy;
		res.pix = '0;
		res.st = frbm_pkg::ST_OK;
		case (r.kind)
			frbm_pkg::REQ_WRITE, frbm_pkg::REQ_READ: begin
				if (lx >= w || ty >= h) res.st = frbm_pkg::ST_COORD;
				else if (r.kind == frbm_pkg::REQ_WRITE) frame_img[ty*mw+lx] = r.pv;
				else res.pix = frame_img[ty*mw+lx];
			end
			frbm_pkg::REQ_COPY, frbm_pkg::REQ_FLIPROW, frbm_pkg::REQ_FLIPCOL: begin
				if (lx >= w || by >= h) res.st = frbm_pkg::ST_COORD;
				else begin
					if (rx >= w) rx = w - 1;
					if (ty >= h) ty = h - 1;
					if (lx > rx || by > ty) res.st = frbm_pkg::ST_COORD;
				end
				if (res.st == frbm_pkg::ST_OK && r.kind == frbm_pkg::REQ_COPY && dx >= w)
					res.st = frbm_pkg::ST_COORD;
				if (res.st == frbm_pkg::ST_OK) begin
					cols = rx - lx + 1;
					rows = ty - by + 1;
					for (int j = 0; j < rows; j++)
						for (int i = 0; i < cols; i++)
							region_buf[j*mw+i] = frame_img[(by+j)*mw+lx+i];
					if (r.kind == frbm_pkg::REQ_COPY) begin
						if (dy >= h) dy = h - 1;
						first = (dy + 1 >= rows) ? dy + 1 - rows : 0;
						for (int j = first; j <= dy; j++)
							for (int i = 0; i < cols && dx + i < w; i++)
								frame_img[j*mw+dx+i] = region_buf[(j-first)*mw+i];
					end else begin
						for (int j = 0; j < rows; j++)
							for (int i = 0; i < cols; i++) begin
								sv = (r.kind == frbm_pkg::REQ_FLIPROW) ? rows - 1 - j : j;
								su = (r.kind == frbm_pkg::REQ_FLIPCOL) ? cols - 1 - i : i;
								frame_img[(by+j)*mw+lx+i] = region_buf[sv*mw+su];
							end
					end
				end
			end
			frbm_pkg::REQ_REPLACE: begin
				found = 1'b0;
				for (int j = 0; j < h; j++)
					for (int i = 0; i < w; i++)
						if (frame_img[j*mw+i] == r.pv) begin
							frame_img[j*mw+i] = r.nv;
							found = 1'b1;
						end
				if (!found) res.st = frbm_pkg::ST_NOTFOUND;
			end
			default: ;
		endcase
		return res;
	endfunction

	// result checker: done can't be stalled, so sample every edge
	always @(posedge clk) begin
		blit_res_t e;
		if (done) begin
			res_cnt++;
			if (pending_q.size() == 0) begin
				$display("%0t: result with nothing expected: pix=%h st=%0d",
					$time, read_pixel, status);
				fail_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (read_pixel !== e.pix) begin
					$display("%0t: read_pixel expected %h actual %h", $time, e.pix, read_pixel);
					fail_cnt++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (done || accepted_now || cfg_valid) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 1500000) begin
			$display("%0t: timeout, no progress", $time);
			$display("testbench: FAIL");
			$finish;
		end
	end
	assign accepted_now = start && !busy;

	// present one request, hold until taken, then maybe idle
	task automatic send_req(blit_req_t r, bit known, logic [23:0] epix, logic [1:0] est);
		blit_res_t p;
		req_type <= r.kind;
		first_col <= r.lx; first_row <= r.ty;
		second_col <= r.rx; second_row <= r.by;
		dest_col <= r.dx; dest_row <= r.dy;
		pixel_value <= r.pv; replacement_value <= r.nv;
		start <= 1'b1;
		do @(posedge clk); while (!(start && !busy));
		p = blit_predict(r);
		if (known && (p.pix !== epix || p.st !== est))
			$display("%0t: note: table entry differs from prediction", $time);
		if (known) begin
			p.pix = epix;
			p.st = est;
		end
		pending_q.push_back(p);
		req_cnt++;
		if (allow_idle && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// register write once the engine has drained
	task automatic write_reg(logic idx, logic [8:0] val);
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == frbm_pkg::REG_WIDTH) width_reg = val;
		else height_reg = val;
		cfg_cnt++;
	endtask

	function automatic blit_req_t mk(logic [2:0] k, int lx, int ty, int rx, int by,
			int dx, int dy, logic [23:0] pv, logic [23:0] nv);
		blit_req_t r;
		r.kind = k; r.lx = 16'(lx); r.ty = 16'(ty); r.rx = 16'(rx); r.by = 16'(by);
		r.dx = 16'(dx); r.dy = 16'(dy); r.pv = pv; r.nv = nv;
		return r;
	endfunction

	function automatic logic [15:0] pick_crd(int lim);
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, lim));
	endfunction

	// random request shaped toward valid, small regions
	function automatic blit_req_t random_req();
		blit_req_t r;
		int w, h, sel, a, b;
		w = used_width();
		h = used_height();
		sel = $urandom_range(0, 99);
		r.kind = (sel < 15) ? frbm_pkg::REQ_WRITE : (sel < 30) ? frbm_pkg::REQ_READ :
			(sel < 50) ? frbm_pkg::REQ_COPY : (sel < 62) ? frbm_pkg::REQ_FLIPROW :
			(sel < 74) ? frbm_pkg::REQ_FLIPCOL : (sel < 88) ? frbm_pkg::REQ_REPLACE :
			3'($urandom_range(6, 7));
		r.lx = pick_crd(w - 1);
		r.by = pick_crd(h - 1);
		r.rx = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'(r.lx + $urandom_range(0, 5));
		r.ty = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'(r.by + $urandom_range(0, 5));
		if (r.kind == frbm_pkg::REQ_WRITE || r.kind == frbm_pkg::REQ_READ)
			r.ty = pick_crd(h - 1);
		r.dx = pick_crd(w - 1);
		r.dy = pick_crd(h + 2);
		a = $urandom_range(0, w - 1);
		b = $urandom_range(0, h - 1);
		r.pv = ($urandom_range(0, 9) < 7 && r.kind == frbm_pkg::REQ_REPLACE) ?
			frame_img[b*frbm_pkg::MAX_WIDTH+a] : 24'($urandom);
		r.nv = 24'($urandom);
		if (sel >= 95) begin
			r = mk(3'($urandom), $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, 24'($urandom), 24'($urandom));
			if (r.kind == frbm_pkg::REQ_REPLACE && w * h > 4096) r.kind = frbm_pkg::REQ_READ;
		end
		return r;
	endfunction

	dir_row_t dir_tab [20];
	int       dims [9][2] = '{'{0, 0}, '{1, 511}, '{511, 1}, '{16, 16}, '{5, 9},
		'{256, 4}, '{300, 7}, '{12, 256}, '{256, 256}};

	initial begin
		dir_tab[0]  = '{mk(frbm_pkg::REQ_WRITE, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 0), 1, 24'h0,
			frbm_pkg::ST_OK};
		dir_tab[1]  = '{mk(frbm_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 24'hFFFFFF,
			frbm_pkg::ST_OK};
		dir_tab[2]  = '{mk(frbm_pkg::REQ_WRITE, 255, 255, 0, 0, 0, 0, 24'h000000, 0), 1,
			24'h0, frbm_pkg::ST_OK};
		dir_tab[3]  = '{mk(frbm_pkg::REQ_READ, 255, 255, 0, 0, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_OK};
		dir_tab[4]  = '{mk(frbm_pkg::REQ_READ, 256, 0, 0, 0, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[5]  = '{mk(frbm_pkg::REQ_READ, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[6]  = '{mk(frbm_pkg::REQ_WRITE, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 24'hFFFFFF,
			0), 1, 24'h0, frbm_pkg::ST_COORD};
		dir_tab[7]  = '{mk(frbm_pkg::REQ_COPY, 256, 3, 260, 0, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[8]  = '{mk(frbm_pkg::REQ_FLIPROW, 0, 300, 3, 256, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[9]  = '{mk(frbm_pkg::REQ_FLIPCOL, 10, 3, 5, 0, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[10] = '{mk(frbm_pkg::REQ_COPY, 0, 2, 3, 5, 0, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		dir_tab[11] = '{mk(frbm_pkg::REQ_COPY, 0, 3, 3, 0, 256, 0, 0, 0), 1, 24'h0,
			frbm_pkg::ST_COORD};
		// right column and top row clipped, paste floored at row 0
		dir_tab[12] = '{mk(frbm_pkg::REQ_COPY, 250, 16'hFFFF, 16'hFFFF, 250, 0, 2, 0, 0),
			0, 0, 0};
		// paste with columns past the right edge dropped, dest row clipped
		dir_tab[13] = '{mk(frbm_pkg::REQ_COPY, 0, 4, 5, 0, 253, 16'hFFFF, 0, 0), 0, 0, 0};
		dir_tab[14] = '{mk(frbm_pkg::REQ_FLIPROW, 0, 3, 4, 0, 0, 0, 0, 0), 0, 0, 0};
		dir_tab[15] = '{mk(frbm_pkg::REQ_FLIPCOL, 248, 255, 255, 251, 0, 0, 0, 0), 0, 0, 0};
		dir_tab[16] = '{mk(frbm_pkg::REQ_REPLACE, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'h00ABCD),
			0, 0, 0};
		dir_tab[17] = '{mk(frbm_pkg::REQ_REPLACE, 0, 0, 0, 0, 0, 0, 24'h777777, 24'h1), 1,
			24'h0, frbm_pkg::ST_NOTFOUND};
		dir_tab[18] = '{mk(3'd6, 1, 1, 1, 1, 1, 1, 24'h5A5A5A, 24'h1), 1, 24'h0,
			frbm_pkg::ST_OK};
		dir_tab[19] = '{mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 24'h0, frbm_pkg::ST_OK};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cover the whole frame: one pixel, then double along the row and down
		write_reg(frbm_pkg::REG_WIDTH, 9'd256);
		write_reg(frbm_pkg::REG_HEIGHT, 9'd256);
		send_req(mk(frbm_pkg::REQ_WRITE, 0, 0, 0, 0, 0, 0, 24'h123456, 0), 1, 24'h0,
			frbm_pkg::ST_OK);
		for (int k = 1; k < frbm_pkg::MAX_WIDTH; k *= 2)
			send_req(mk(frbm_pkg::REQ_COPY, 0, 0, k - 1, 0, k, 0, 0, 0), 0, 0, 0);
		for (int k = 1; k < frbm_pkg::MAX_HEIGHT; k *= 2)
			send_req(mk(frbm_pkg::REQ_COPY, 0, k - 1, frbm_pkg::MAX_WIDTH - 1, 0, 0,
				2*k - 1, 0, 0), 0, 0, 0);

		// directed table
		foreach (dir_tab[n])
			send_req(dir_tab[n].r, dir_tab[n].known, dir_tab[n].epix, dir_tab[n].est);

		// random phases over several image sizes; no idling in the last one
		for (int p = 0; p < 9; p++) begin
			write_reg(frbm_pkg::REG_WIDTH, 9'(dims[p][0]));
			write_reg(frbm_pkg::REG_HEIGHT, 9'(dims[p][1]));
			if (p == 8) allow_idle = 1'b0;
			repeat (8) send_req(random_req(), 0, 0, 0);
		end

		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Covered %0d requests, %0d results, %0d register writes, %0d sizes.",
			req_cnt, res_cnt, cfg_cnt, 9);
		if (fail_cnt == 0 && pending_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

// ===== frame_region_blit_mirror_top.f =====
rtl/frbm_pkg.sv
rtl/frbm_ram.sv
rtl/frbm_seq.sv
rtl/frame_region_blit_mirror_top.sv
sim/testbench.sv
